FILE: rtl/core/coap_mp_pkg.sv
// Shared types, codes and helpers for the CoAP message parser.
package coap_mp_pkg;

  localparam int unsigned MAX_OPTIONS_DEF = 8;
  localparam logic [8:0]  EXT_BASE        = 9'd13;
  localparam logic [3:0]  NIB_EXT         = 4'd13;
  localparam logic [7:0]  MARKER_BYTE     = 8'hFF;

  typedef enum logic [7:0] {
    PH_HDR     = 8'b0000_0001,
    PH_TOKEN   = 8'b0000_0010,
    PH_OPT     = 8'b0000_0100,
    PH_EXT_D   = 8'b0000_1000,
    PH_EXT_L   = 8'b0001_0000,
    PH_VALUE   = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_DISCARD = 8'b1000_0000
  } phase_t;

  typedef enum logic [3:0] {
    EV_HDR_BYTE  = 4'd0,
    EV_HDR_DONE  = 4'd1,
    EV_TOKEN     = 4'd2,
    EV_OPT_EXT   = 4'd3,
    EV_OPT_READY = 4'd4,
    EV_OPT_VALUE = 4'd5,
    EV_MARKER    = 4'd6,
    EV_PAYLOAD   = 4'd7,
    EV_ERROR     = 4'd8
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TRUNCATED = 2'd1,
    ERR_TOO_MANY  = 2'd2
  } err_t;

  // Parser state apart from the option counter, whose width follows MAX_OPTIONS.
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  header_count;
    logic [1:0]  hdr_version;
    logic [1:0]  hdr_type;
    logic [3:0]  hdr_token_len;
    logic [7:0]  hdr_code;
    logic [15:0] hdr_msg_id;
    logic [3:0]  token_left;
    logic [8:0]  cur_delta;
    logic [8:0]  cur_length;
    logic [8:0]  value_left;
  } pstate_t;

  typedef struct packed {
    event_t      event_res;
    logic [1:0]  version;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [7:0]  msg_code;
    logic [15:0] message_id;
    logic [2:0]  option_index;
    logic [8:0]  option_delta;
    logic [8:0]  option_length;
    logic [7:0]  data_byte;
    logic        message_end;
    err_t        error_kind;
  } result_t;

  localparam pstate_t PSTATE_RESET = '{
    phase: PH_HDR, header_count: 2'd0, hdr_version: 2'd0, hdr_type: 2'd0,
    hdr_token_len: 4'd0, hdr_code: 8'd0, hdr_msg_id: 16'd0, token_left: 4'd0,
    cur_delta: 9'd0, cur_length: 9'd0, value_left: 9'd0
  };

  // Option header complete: go to the value bytes, or straight to the next option.
  function automatic pstate_t opt_ready(input pstate_t s);
    pstate_t r;
    r = s;
    if (s.cur_length == 9'd0) begin
      r.phase = PH_OPT;
    end else begin
      r.value_left = s.cur_length;
      r.phase      = PH_VALUE;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/coap_mp_step.sv
// Per-byte next-state and event logic of the CoAP message parser.
module coap_mp_step
  import coap_mp_pkg::*;
#(
  parameter int unsigned MAX_OPTIONS = MAX_OPTIONS_DEF,
  parameter int unsigned OSW         = $clog2(MAX_OPTIONS + 1)
) (
  input  pstate_t          st,
  input  logic [OSW-1:0]   opts,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output pstate_t          st_next,
  output logic [OSW-1:0]   opts_next,
  output result_t          res
);

  localparam int unsigned IDXW = OSW + 3;

  event_t           ev;
  err_t             err;
  logic [7:0]       data;
  logic [IDXW-1:0]  idx_wide;

  always_comb begin
    st_next   = st;
    opts_next = opts;
    ev        = EV_ERROR;
    err       = ERR_NONE;
    data      = 8'd0;

    unique case (st.phase)
      PH_HDR: begin
        unique case (st.header_count)
          2'd0: begin
            st_next.hdr_version   = in_byte[7:6];
            st_next.hdr_type      = in_byte[5:4];
            st_next.hdr_token_len = in_byte[3:0];
            ev = EV_HDR_BYTE;
          end
          2'd1: begin
            st_next.hdr_code = in_byte;
            ev = EV_HDR_BYTE;
          end
          2'd2: begin
            st_next.hdr_msg_id = {in_byte, 8'd0};
            ev = EV_HDR_BYTE;
          end
          default: begin
            st_next.hdr_msg_id = {st.hdr_msg_id[15:8], in_byte};
            st_next.token_left = st.hdr_token_len;
            st_next.phase      = (st.hdr_token_len != 4'd0) ? PH_TOKEN : PH_OPT;
            ev = EV_HDR_DONE;
          end
        endcase
        st_next.header_count = st.header_count + 2'd1;
      end
      PH_TOKEN: begin
        ev   = EV_TOKEN;
        data = in_byte;
        st_next.token_left = st.token_left - 4'd1;
        if (st.token_left == 4'd1) st_next.phase = PH_OPT;
      end
      PH_OPT: begin
        if (in_byte == MARKER_BYTE) begin
          ev = EV_MARKER;
          st_next.phase = PH_PAYLOAD;
        end else if (opts >= OSW'(MAX_OPTIONS)) begin
          err = ERR_TOO_MANY;
          st_next.phase = PH_DISCARD;
        end else begin
          opts_next = opts + OSW'(1);
          st_next.cur_delta  = {5'd0, in_byte[7:4]};
          st_next.cur_length = {5'd0, in_byte[3:0]};
          if (in_byte[7:4] == NIB_EXT) begin
            ev = EV_OPT_EXT;
            st_next.phase = PH_EXT_D;
          end else if (in_byte[3:0] == NIB_EXT) begin
            ev = EV_OPT_EXT;
            st_next.phase = PH_EXT_L;
          end else begin
            ev = EV_OPT_READY;
            st_next = opt_ready(st_next);
          end
        end
      end
      PH_EXT_D: begin
        st_next.cur_delta = EXT_BASE + {1'b0, in_byte};
        if (st.cur_length == EXT_BASE) begin
          ev = EV_OPT_EXT;
          st_next.phase = PH_EXT_L;
        end else begin
          ev = EV_OPT_READY;
          st_next = opt_ready(st_next);
        end
      end
      PH_EXT_L: begin
        st_next.cur_length = EXT_BASE + {1'b0, in_byte};
        ev = EV_OPT_READY;
        st_next = opt_ready(st_next);
      end
      PH_VALUE: begin
        ev   = EV_OPT_VALUE;
        data = in_byte;
        st_next.value_left = st.value_left - 9'd1;
        if (st.value_left == 9'd1) st_next.phase = PH_OPT;
      end
      PH_PAYLOAD: begin
        ev   = EV_PAYLOAD;
        data = in_byte;
      end
      default: begin
        err = ERR_TOO_MANY;
        st_next.phase = PH_DISCARD;
      end
    endcase

    // last byte must leave the message complete or inside a non-empty payload
    if (in_last && ev != EV_ERROR) begin
      if (ev == EV_MARKER ||
          (st_next.phase != PH_OPT && st_next.phase != PH_PAYLOAD)) begin
        ev   = EV_ERROR;
        err  = ERR_TRUNCATED;
        data = 8'd0;
      end
    end
  end

  assign idx_wide = IDXW'(opts_next) - IDXW'(1);

  always_comb begin
    res.event_res     = ev;
    res.version       = st_next.hdr_version;
    res.msg_type      = st_next.hdr_type;
    res.token_length  = st_next.hdr_token_len;
    res.msg_code      = st_next.hdr_code;
    res.message_id    = st_next.hdr_msg_id;
    res.option_index  = (opts_next != '0) ? idx_wide[2:0] : 3'd0;
    res.option_delta  = st_next.cur_delta;
    res.option_length = st_next.cur_length;
    res.data_byte     = data;
    res.message_end   = in_last;
    res.error_kind    = err;
  end

endmodule

FILE: rtl/core/coap_mp_outreg.sv
// Result register with valid/ready handshake for the CoAP message parser.
module coap_mp_outreg
  import coap_mp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_d,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    can_load,
  output result_t res_q
);

  // a new result may land in the same cycle the held one transfers
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: rtl/core/coap_message_parser_top.sv
// Top level of the CoAP message parser: state registers, step logic, result register.
//
// Parses a CoAP datagram one byte per cycle and produces one event record per
// byte, in the cycle after the byte transfers. Input and output run at full rate:
// a byte is taken in every cycle in which the result register is empty or its
// result transfers in that same cycle. The figure is set by the single
// parser-state update that each byte makes. The byte flagged by in_last closes
// the datagram and returns the parser to its reset state for the next one.
// There is no clearing pass after reset.
module coap_message_parser_top
  import coap_mp_pkg::*;
#(
  parameter int unsigned MAX_OPTIONS = MAX_OPTIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_res,
  output logic [1:0]  version,
  output logic [1:0]  msg_type,
  output logic [3:0]  token_length,
  output logic [7:0]  msg_code,
  output logic [15:0] message_id,
  output logic [2:0]  option_index,
  output logic [8:0]  option_delta,
  output logic [8:0]  option_length,
  output logic [7:0]  data_byte,
  output logic        message_end,
  output logic [1:0]  error_kind
);

  localparam int unsigned OSW = $clog2(MAX_OPTIONS + 1);

  pstate_t        pstate;
  pstate_t        pstate_next;
  logic [OSW-1:0] options_seen;
  logic [OSW-1:0] options_seen_next;
  result_t        res_d;
  result_t        res_q;
  logic           accept;

  assign accept = in_valid && in_ready;

  coap_mp_step #(
    .MAX_OPTIONS (MAX_OPTIONS),
    .OSW         (OSW)
  ) u_step (
    .st        (pstate),
    .opts      (options_seen),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .st_next   (pstate_next),
    .opts_next (options_seen_next),
    .res       (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate       <= PSTATE_RESET;
      options_seen <= '0;
    end else if (accept) begin
      if (in_last) begin
        pstate       <= PSTATE_RESET;
        options_seen <= '0;
      end else begin
        pstate       <= pstate_next;
        options_seen <= options_seen_next;
      end
    end
  end

  coap_mp_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_d     (res_d),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (in_ready),
    .res_q     (res_q)
  );

  assign event_res     = res_q.event_res;
  assign version       = res_q.version;
  assign msg_type      = res_q.msg_type;
  assign token_length  = res_q.token_length;
  assign msg_code      = res_q.msg_code;
  assign message_id    = res_q.message_id;
  assign option_index  = res_q.option_index;
  assign option_delta  = res_q.option_delta;
  assign option_length = res_q.option_length;
  assign data_byte     = res_q.data_byte;
  assign message_end   = res_q.message_end;
  assign error_kind    = res_q.error_kind;

endmodule

FILE: rtl/core/coap_mp_checker.sv
// Port-level assertions for the CoAP message parser, bound to the top level.
module coap_mp_checker
  import coap_mp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  event_res,
  input logic [7:0]  data_byte,
  input logic [2:0]  option_index,
  input logic [8:0]  option_delta,
  input logic [1:0]  error_kind
);

  // error kind is reported with, and only with, an error event
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((error_kind != ERR_NONE) == (event_res == EV_ERROR)))
    else $error("error_kind and event_res disagree");

  // data only passes through on token, option value and payload events
  a_data_pass: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_byte != 8'd0 |->
      (event_res == EV_TOKEN || event_res == EV_OPT_VALUE || event_res == EV_PAYLOAD))
    else $error("data_byte set on a non-data event");

  // header bytes come before any option of the datagram
  a_hdr_no_opt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_HDR_BYTE || event_res == EV_HDR_DONE) |->
      option_index == 3'd0 && option_delta == 9'd0)
    else $error("option fields set during header");

  // a result stalled at the output keeps its event
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res))
    else $error("stalled result changed");

  // with the output free the parser takes input
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind coap_message_parser_top coap_mp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .event_res    (event_res),
  .data_byte    (data_byte),
  .option_index (option_index),
  .option_delta (option_delta),
  .error_kind   (error_kind)
);

FILE: sim/coap_parse_checker.sv
// Scoreboard for the CoAP message parser: predicts each byte's event record and checks it.
`timescale 1ns / 100ps
module coap_parse_checker
  import coap_mp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  event_res,
  input  logic [1:0]  version,
  input  logic [1:0]  msg_type,
  input  logic [3:0]  token_length,
  input  logic [7:0]  msg_code,
  input  logic [15:0] message_id,
  input  logic [2:0]  option_index,
  input  logic [8:0]  option_delta,
  input  logic [8:0]  option_length,
  input  logic [7:0]  data_byte,
  input  logic        message_end,
  input  logic [1:0]  error_kind,
  output int          fails,
  output int          pending,
  output int          checked
);

  localparam int OPT_LIMIT = MAX_OPTIONS_DEF;
  localparam int PRINT_CAP = 40;

  // predicted parser state
  phase_t      cur_phase;
  logic [1:0]  hdr_idx;
  logic [1:0]  pv_version;
  logic [1:0]  pv_type;
  logic [3:0]  pv_tkl;
  logic [7:0]  pv_code;
  logic [15:0] pv_mid;
  logic [3:0]  tok_left;
  logic [8:0]  opt_delta_q;
  logic [8:0]  opt_len_q;
  logic [8:0]  val_left;
  logic [3:0]  opt_count;

  result_t     event_q[$];

  function automatic void restart_parse();
    cur_phase   = PH_HDR;
    hdr_idx     = 2'd0;
    pv_version  = 2'd0;
    pv_type     = 2'd0;
    pv_tkl      = 4'd0;
    pv_code     = 8'd0;
    pv_mid      = 16'd0;
    tok_left    = 4'd0;
    opt_delta_q = 9'd0;
    opt_len_q   = 9'd0;
    val_left    = 9'd0;
    opt_count   = 4'd0;
  endfunction

  // option header complete: zero-length options go straight back to option parsing
  function automatic void open_value();
    if (opt_len_q == 9'd0) begin
      cur_phase = PH_OPT;
    end else begin
      val_left  = opt_len_q;
      cur_phase = PH_VALUE;
    end
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b, input logic lst);
    result_t    r;
    event_t     ev;
    logic [7:0] data;
    err_t       err;
    ev   = EV_ERROR;
    data = 8'd0;
    err  = ERR_NONE;
    case (cur_phase)
      PH_HDR: begin
        case (hdr_idx)
          2'd0: begin
            pv_version = b[7:6];
            pv_type    = b[5:4];
            pv_tkl     = b[3:0];
            ev         = EV_HDR_BYTE;
          end
          2'd1: begin
            pv_code = b;
            ev      = EV_HDR_BYTE;
          end
          2'd2: begin
            pv_mid = {b, 8'h00};
            ev     = EV_HDR_BYTE;
          end
          default: begin
            pv_mid[7:0] = b;
            ev          = EV_HDR_DONE;
            tok_left    = pv_tkl;
            cur_phase   = (pv_tkl != 4'd0) ? PH_TOKEN : PH_OPT;
          end
        endcase
        hdr_idx = hdr_idx + 2'd1;
      end
      PH_TOKEN: begin
        ev       = EV_TOKEN;
        data     = b;
        tok_left = tok_left - 4'd1;
        if (tok_left == 4'd0) cur_phase = PH_OPT;
      end
      PH_OPT: begin
        if (b == MARKER_BYTE) begin
          ev        = EV_MARKER;
          cur_phase = PH_PAYLOAD;
        end else if (opt_count >= OPT_LIMIT) begin
          err       = ERR_TOO_MANY;
          cur_phase = PH_DISCARD;
        end else begin
          opt_count   = opt_count + 4'd1;
          opt_delta_q = {5'd0, b[7:4]};
          opt_len_q   = {5'd0, b[3:0]};
          if (b[7:4] == NIB_EXT) begin
            ev        = EV_OPT_EXT;
            cur_phase = PH_EXT_D;
          end else if (b[3:0] == NIB_EXT) begin
            ev        = EV_OPT_EXT;
            cur_phase = PH_EXT_L;
          end else begin
            ev = EV_OPT_READY;
            open_value();
          end
        end
      end
      PH_EXT_D: begin
        opt_delta_q = EXT_BASE + b;
        if (opt_len_q == 9'(NIB_EXT)) begin
          ev        = EV_OPT_EXT;
          cur_phase = PH_EXT_L;
        end else begin
          ev = EV_OPT_READY;
          open_value();
        end
      end
      PH_EXT_L: begin
        opt_len_q = EXT_BASE + b;
        ev        = EV_OPT_READY;
        open_value();
      end
      PH_VALUE: begin
        ev       = EV_OPT_VALUE;
        data     = b;
        val_left = val_left - 9'd1;
        if (val_left == 9'd0) cur_phase = PH_OPT;
      end
      PH_PAYLOAD: begin
        ev   = EV_PAYLOAD;
        data = b;
      end
      default: begin
        // after the option limit the rest of the datagram is dropped
        err       = ERR_TOO_MANY;
        cur_phase = PH_DISCARD;
      end
    endcase

    // datagram ends mid-structure, or on a marker with no payload
    if (lst && ev != EV_ERROR) begin
      if (ev == EV_MARKER || (cur_phase != PH_OPT && cur_phase != PH_PAYLOAD)) begin
        ev   = EV_ERROR;
        err  = ERR_TRUNCATED;
        data = 8'd0;
      end
    end

    r.event_res     = ev;
    r.version       = pv_version;
    r.msg_type      = pv_type;
    r.token_length  = pv_tkl;
    r.msg_code      = pv_code;
    r.message_id    = pv_mid;
    r.option_index  = (opt_count != 4'd0) ? 3'(opt_count - 4'd1) : 3'd0;
    r.option_delta  = opt_delta_q;
    r.option_length = opt_len_q;
    r.data_byte     = data;
    r.message_end   = lst;
    r.error_kind    = err;
    if (lst) restart_parse();
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (fails < PRINT_CAP) $display("[%0t] MISMATCH %s", $time, what);
    fails = fails + 1;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s: got %0h, want %0h", checked, name, got, want));
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      restart_parse();
      event_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          report_mismatch("record transfer with nothing outstanding");
        end else begin
          want = event_q.pop_front();
          check_field("event_res", 16'(event_res), 16'(want.event_res));
          check_field("version", 16'(version), 16'(want.version));
          check_field("msg_type", 16'(msg_type), 16'(want.msg_type));
          check_field("token_length", 16'(token_length), 16'(want.token_length));
          check_field("msg_code", 16'(msg_code), 16'(want.msg_code));
          check_field("message_id", message_id, want.message_id);
          check_field("option_index", 16'(option_index), 16'(want.option_index));
          check_field("option_delta", 16'(option_delta), 16'(want.option_delta));
          check_field("option_length", 16'(option_length), 16'(want.option_length));
          check_field("data_byte", 16'(data_byte), 16'(want.data_byte));
          check_field("message_end", 16'(message_end), 16'(want.message_end));
          check_field("error_kind", 16'(error_kind), 16'(want.error_kind));
          checked = checked + 1;
        end
      end
      if (in_valid && in_ready) event_q.push_back(parse_byte(in_byte, in_last));
    end
    pending <= event_q.size();
  end

endmodule

FILE: sim/tb_coap_message_parser_top.sv
// Testbench top for the CoAP message parser: datagram stimulus, sink back-pressure, verdict.
`timescale 1ns / 100ps
module tb_coap_message_parser_top;
  import coap_mp_pkg::*;

  typedef enum int { DG_GOOD, DG_CUT, DG_TOO_MANY, DG_NOISE } dgram_kind_t;

  localparam int ITEMS = 600;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte   = 8'd0;
  logic        in_last   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  event_res;
  logic [1:0]  version;
  logic [1:0]  msg_type;
  logic [3:0]  token_length;
  logic [7:0]  msg_code;
  logic [15:0] message_id;
  logic [2:0]  option_index;
  logic [8:0]  option_delta;
  logic [8:0]  option_length;
  logic [7:0]  data_byte;
  logic        message_end;
  logic [1:0]  error_kind;

  int fails;
  int pending;
  int checked;

  logic [7:0] dgram[$];
  int         n_bytes = 0;
  int         n_dgram = 0;
  int         kind_count[4];
  bit         calm = 1'b0;
  int         gap_odds = 3;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  coap_message_parser_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .version(version), .msg_type(msg_type),
    .token_length(token_length), .msg_code(msg_code), .message_id(message_id),
    .option_index(option_index), .option_delta(option_delta),
    .option_length(option_length), .data_byte(data_byte),
    .message_end(message_end), .error_kind(error_kind)
  );

  coap_parse_checker scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .version(version), .msg_type(msg_type),
    .token_length(token_length), .msg_code(msg_code), .message_id(message_id),
    .option_index(option_index), .option_delta(option_delta),
    .option_length(option_length), .data_byte(data_byte),
    .message_end(message_end), .error_kind(error_kind),
    .fails(fails), .pending(pending), .checked(checked)
  );

  // one byte per transfer; valid stays up between back-to-back bytes
  task automatic send_datagram();
    for (int i = 0; i < dgram.size(); i++) begin
      if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= dgram[i];
      in_last  <= (i == dgram.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      n_bytes++;
    end
    n_dgram++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // sink side: stall bursts, with the stall rate re-picked now and then
  initial begin : sink
    int hold;
    int stall_odds;
    int cyc;
    hold       = 0;
    stall_odds = 4;
    cyc        = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 50 == 0)
        stall_odds = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 4 : 12);
      if (calm) begin
        hold = 0;
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
        hold = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int          pick;
    dgram_kind_t kind;
    int          tkl;
    int          nopt;
    int          dn;
    int          ln;
    int          vlen;
    int          keep;
    logic [7:0]  ext;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // header only, clean end
    dgram = {8'h00, 8'h00, 8'h00, 8'h00};
    send_datagram();
    // all-ones header: token length 15, ends inside the token
    dgram = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_datagram();
    // token, extended delta, value, nibble-14 option, marker, one payload byte
    dgram = {8'h41, 8'h01, 8'h12, 8'h34, 8'hAA, 8'hD1, 8'hFF, 8'h5A, 8'hE0, 8'hFF, 8'h99};
    send_datagram();
    // marker as the final byte: empty payload
    dgram = {8'h40, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_datagram();
    // one option header past the limit, then a byte that must be dropped
    dgram = {8'h40, 8'h00, 8'h00, 8'h00};
    repeat (MAX_OPTIONS_DEF) dgram.push_back(8'h00);
    dgram.push_back(8'h11);
    dgram.push_back(8'h22);
    send_datagram();

    // hold the sender until the parser has emptied out
    drain_results();

    while (n_bytes < ITEMS) begin
      calm     = (n_bytes >= ITEMS - 120);
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 3 : 12);
      pick     = $urandom_range(0, 19);
      kind     = (pick < 13) ? DG_GOOD : (pick < 16) ? DG_CUT :
                 (pick < 18) ? DG_TOO_MANY : DG_NOISE;
      kind_count[kind]++;
      dgram.delete();
      if (kind == DG_NOISE) begin
        repeat ($urandom_range(1, 12)) dgram.push_back(8'($urandom));
      end else begin
        tkl = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        dgram.push_back({2'($urandom), 2'($urandom), 4'(tkl)});
        repeat (3) dgram.push_back(8'($urandom));
        repeat (tkl) dgram.push_back(8'($urandom));
        nopt = (kind == DG_TOO_MANY) ? $urandom_range(MAX_OPTIONS_DEF + 1, MAX_OPTIONS_DEF + 3)
                                     : $urandom_range(0, 5);
        for (int k = 0; k < nopt; k++) begin
          dn = $urandom_range(0, 15);
          ln = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
          if (dn == 15 && ln == 15) ln = 14;  // 0xFF would read as the marker
          ext = 8'($urandom_range(0, 3));
          if ($urandom_range(0, 149) == 0) begin
            ln  = 13;
            ext = 8'hFF;  // longest value
          end
          dgram.push_back({4'(dn), 4'(ln)});
          if (dn == 13) dgram.push_back(8'($urandom));
          if (ln == 13) dgram.push_back(ext);
          vlen = (ln == 13) ? 13 + ext : ln;
          repeat (vlen) dgram.push_back(8'($urandom));
        end
        if ($urandom_range(0, 2) != 0) begin
          dgram.push_back(MARKER_BYTE);
          repeat ($urandom_range(1, 10)) dgram.push_back(8'($urandom));
        end
        if (kind == DG_CUT && dgram.size() > 1) begin
          keep = $urandom_range(1, dgram.size() - 1);
          while (dgram.size() > keep) void'(dgram.pop_back());
        end
      end
      send_datagram();
      if ($urandom_range(0, 24) == 0) drain_results();
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Covered %0d datagrams, %0d bytes, %0d event records compared.",
             n_dgram, n_bytes, checked);
    $display("Random mix: %0d well formed, %0d cut short, %0d over the option limit, %0d noise.",
             kind_count[DG_GOOD], kind_count[DG_CUT], kind_count[DG_TOO_MANY],
             kind_count[DG_NOISE]);
    if (fails == 0) begin
      $display("tb_coap_message_parser_top: clean");
    end else begin
      $display("tb_coap_message_parser_top: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("Timeout with %0d records outstanding", pending);
    $display("tb_coap_message_parser_top: errors");
    $finish;
  end

endmodule
